[design/rsdz_pkg.sv]
// ---------------------------------------------------------------------------
// rsdz_pkg
// Shared widths, constants and stage records for the radial dead zone block.
// ---------------------------------------------------------------------------
package rsdz_pkg;

  localparam int AXIS_BITS  = 16;
  localparam int DZ_W       = 15;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 26;
  localparam int DIV_W      = 24;
  localparam int Q_W        = 16;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = Q_W;

  localparam logic [DZ_W-1:0] DZ_RESET  = 15'd7849;
  localparam logic [15:0]     AXIS_FULL = 16'd32767;
  localparam logic [22:0]     CLIP_MAX  = {AXIS_FULL[14:0], 8'd0};

  // One square root stage: operand, partial root and remainder plus the
  // sample that rides along.
  typedef struct packed {
    logic                     valid;
    logic                     dz_hit;
    logic signed [AXIS_BITS-1:0] x;
    logic signed [AXIS_BITS-1:0] y;
    logic [SQ_W-1:0]          s;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
  } sqrt_t;

  // Side information that travels beside the dividers.
  typedef struct packed {
    logic valid;
    logic dz_hit;
    logic neg_x;
    logic neg_y;
    logic dz_full;
  } dmeta_t;

endpackage

[design/rsdz_div.sv]
// ---------------------------------------------------------------------------
// rsdz_div
// Pipelined restoring divider, one quotient bit per stage.
// The high part of the numerator must be below the divisor.
// ---------------------------------------------------------------------------
module rsdz_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rsdz_pkg::DIV_W-1:0]  hi,
  input  logic [rsdz_pkg::Q_W-1:0]    lo,
  input  logic [rsdz_pkg::DIV_W-1:0]  div,
  output logic [rsdz_pkg::Q_W-1:0]    quo
);

  logic [rsdz_pkg::DIV_W-1:0] rem  [0:rsdz_pkg::DIV_STEPS];
  logic [rsdz_pkg::Q_W-1:0]   low  [0:rsdz_pkg::DIV_STEPS];
  logic [rsdz_pkg::DIV_W-1:0] dv   [0:rsdz_pkg::DIV_STEPS];
  logic [rsdz_pkg::Q_W-1:0]   q    [0:rsdz_pkg::DIV_STEPS];

  assign rem[0] = hi;
  assign low[0] = lo;
  assign dv[0]  = div;
  assign q[0]   = '0;

  for (genvar k = 0; k < rsdz_pkg::DIV_STEPS; k++) begin : g_step
    logic [rsdz_pkg::DIV_W:0] r2;
    logic                     ge;
    logic [rsdz_pkg::DIV_W:0] diff;

    assign r2   = {rem[k], low[k][rsdz_pkg::Q_W-1]};
    assign diff = r2 - {1'b0, dv[k]};
    assign ge   = (r2 >= {1'b0, dv[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[rsdz_pkg::DIV_W-1:0] : r2[rsdz_pkg::DIV_W-1:0];
        low[k+1] <= {low[k][rsdz_pkg::Q_W-2:0], 1'b0};
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][rsdz_pkg::Q_W-2:0], ge};
      end
    end
  end

  assign quo = q[rsdz_pkg::DIV_STEPS];

endmodule

[design/radial_stick_dead_zone.sv]
// ---------------------------------------------------------------------------
// radial_stick_dead_zone
// Circular dead zone for a thumbstick: unit direction and scaled magnitude.
// ---------------------------------------------------------------------------
// Takes one signed X/Y sample per request and returns one result per request,
// in order. Length is floor(sqrt((x*x+y*y) << 16)), i.e. Q.8 counts. Outside
// the dead zone the block returns x/len and y/len in Q1.15 (truncated toward
// zero, saturated) and the magnitude past the dead zone scaled so 32768 is
// full deflection; inside it returns zeros with in_dead_zone set. A new
// request is taken every cycle unless out_stall holds a result; from
// acceptance to the output register the stages are sign/abs, squares,
// sum/compare, 24 square root stages (one root bit each), a clip stage, 16
// divider stages (one quotient bit each, three dividers in parallel) and
// the output stage. The whole pipeline holds while a result waits under
// out_stall. Write dead_zone only while no request is in flight.
// ---------------------------------------------------------------------------
module radial_stick_dead_zone (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [rsdz_pkg::DZ_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      axis_x,
  input  logic signed [15:0]      axis_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [15:0]      dir_x,
  output logic signed [15:0]      dir_y,
  output logic [15:0]             norm_magnitude,
  output logic                    in_dead_zone
);

  localparam int AB = rsdz_pkg::AXIS_BITS;

  logic en;
  logic [rsdz_pkg::DZ_W-1:0] dead_zone;
  logic [2*rsdz_pkg::DZ_W-1:0] dz_sq;

  // Advance everything unless the output holds an untaken result.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= rsdz_pkg::DZ_RESET;
    end else if (cfg_wr_en) begin
      dead_zone <= cfg_wr_data;
    end
  end

  // Dead zone squared, refreshed every cycle; config must only change when idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    dz_sq <= dead_zone * dead_zone;
  end

  // Stage A: sign extend, absolute values.
  logic signed [AB-1:0] xs, ys;
  logic [AB:0]          xw, yw;
  logic                 a_valid;
  logic signed [AB-1:0] a_x, a_y;
  logic [AB-1:0]        a_ax, a_ay;

  assign xs = axis_x[AB-1:0];
  assign ys = axis_y[AB-1:0];
  assign xw = xs[AB-1] ? (AB+1)'(-{xs[AB-1], xs}) : {1'b0, xs};
  assign yw = ys[AB-1] ? (AB+1)'(-{ys[AB-1], ys}) : {1'b0, ys};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_x  <= xs;
      a_y  <= ys;
      a_ax <= xw[AB-1:0];
      a_ay <= yw[AB-1:0];
    end
  end

  // Stage B: squares.
  logic                 b_valid;
  logic signed [AB-1:0] b_x, b_y;
  logic [rsdz_pkg::SQ_W-1:0] b_sqx, b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_x   <= a_x;
      b_y   <= a_y;
      b_sqx <= rsdz_pkg::SQ_W'(a_ax * a_ax);
      b_sqy <= rsdz_pkg::SQ_W'(a_ay * a_ay);
    end
  end

  // Stage C: sum and dead zone compare, seeds the root pipeline.
  rsdz_pkg::sqrt_t sq [0:rsdz_pkg::SQRT_STEPS];
  logic [rsdz_pkg::SQ_W-1:0] c_sum;

  assign c_sum = b_sqx + b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0].valid <= b_valid;
    end
    if (en) begin
      sq[0].dz_hit <= !(c_sum > {2'b00, dz_sq});
      sq[0].x      <= b_x;
      sq[0].y      <= b_y;
      sq[0].s      <= c_sum;
      sq[0].rem    <= '0;
      sq[0].root   <= '0;
    end
  end

  // Square root of {s, 16'b0}: one bit pair per stage, top pair first.
  for (genvar k = 0; k < rsdz_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam int P = rsdz_pkg::SQRT_STEPS - 1 - k;
    logic [47:0]                  n;
    logic [rsdz_pkg::REM_W+1:0]   t;
    logic [rsdz_pkg::REM_W+1:0]   trial;
    logic                         ge;
    logic [rsdz_pkg::REM_W+1:0]   diff;

    assign n     = {sq[k].s, 16'd0};
    assign t     = {sq[k].rem, n[2*P+1 -: 2]};
    assign trial = {2'b00, sq[k].root, 2'b01};
    assign ge    = (t >= trial);
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].valid <= 1'b0;
      end else if (en) begin
        sq[k+1].valid <= sq[k].valid;
      end
      if (en) begin
        sq[k+1].dz_hit <= sq[k].dz_hit;
        sq[k+1].x      <= sq[k].x;
        sq[k+1].y      <= sq[k].y;
        sq[k+1].s      <= sq[k].s;
        sq[k+1].rem    <= ge ? diff[rsdz_pkg::REM_W-1:0] : t[rsdz_pkg::REM_W-1:0];
        sq[k+1].root   <= {sq[k].root[rsdz_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  // Stage M: clip length, subtract dead zone, set up divider operands.
  rsdz_pkg::sqrt_t      r;
  logic [rsdz_pkg::ROOT_W-1:0] clip;
  logic [22:0]          dz8, mag, denom;
  logic [AB:0]          rxw, ryw;
  rsdz_pkg::dmeta_t     dm [0:rsdz_pkg::DIV_STEPS];
  logic [rsdz_pkg::DIV_W-1:0] m_hx, m_hy, m_hn, m_len, m_den;
  logic [rsdz_pkg::Q_W-1:0]   m_ln;

  assign r     = sq[rsdz_pkg::SQRT_STEPS];
  assign clip  = (r.root > {1'b0, rsdz_pkg::CLIP_MAX}) ? {1'b0, rsdz_pkg::CLIP_MAX} : r.root;
  assign dz8   = {dead_zone, 8'd0};
  assign mag   = (clip[22:0] >= dz8) ? clip[22:0] - dz8 : '0;
  assign denom = {rsdz_pkg::AXIS_FULL[14:0] - dead_zone, 8'd0};
  assign rxw   = r.x[AB-1] ? (AB+1)'(-{r.x[AB-1], r.x}) : {1'b0, r.x};
  assign ryw   = r.y[AB-1] ? (AB+1)'(-{r.y[AB-1], r.y}) : {1'b0, r.y};

  always_ff @(posedge clk) begin
    if (rst) begin
      dm[0].valid <= 1'b0;
    end else if (en) begin
      dm[0].valid <= r.valid;
    end
    if (en) begin
      dm[0].dz_hit  <= r.dz_hit;
      dm[0].neg_x   <= r.x[AB-1];
      dm[0].neg_y   <= r.y[AB-1];
      dm[0].dz_full <= (denom == '0);
      m_hx  <= {1'b0, rxw[AB-1:0], 7'd0};
      m_hy  <= {1'b0, ryw[AB-1:0], 7'd0};
      m_len <= r.root;
      m_hn  <= {2'b00, mag[22:1]};
      m_ln  <= {mag[0], 15'd0};
      m_den <= {1'b0, denom};
    end
  end

  // Dividers: x and y by the length, magnitude by the live range.
  logic [rsdz_pkg::Q_W-1:0] qx, qy, qn;

  rsdz_div u_div_x (
    .clk (clk), .en (en), .hi (m_hx), .lo ('0), .div (m_len), .quo (qx)
  );

  rsdz_div u_div_y (
    .clk (clk), .en (en), .hi (m_hy), .lo ('0), .div (m_len), .quo (qy)
  );

  rsdz_div u_div_n (
    .clk (clk), .en (en), .hi (m_hn), .lo (m_ln), .div (m_den), .quo (qn)
  );

  // Carry the side information beside the dividers.
  for (genvar k = 0; k < rsdz_pkg::DIV_STEPS; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (rst) begin
        dm[k+1].valid <= 1'b0;
      end else if (en) begin
        dm[k+1].valid <= dm[k].valid;
      end
      if (en) begin
        dm[k+1].dz_hit  <= dm[k].dz_hit;
        dm[k+1].neg_x   <= dm[k].neg_x;
        dm[k+1].neg_y   <= dm[k].neg_y;
        dm[k+1].dz_full <= dm[k].dz_full;
      end
    end
  end

  // Output stage: sign, saturate, zero inside the dead zone.
  rsdz_pkg::dmeta_t f;
  logic [15:0] dx_next, dy_next, nm_next;

  assign f = dm[rsdz_pkg::DIV_STEPS];

  always_comb begin
    if (f.neg_x) begin
      dx_next = 16'(-qx);
    end else begin
      dx_next = (qx > rsdz_pkg::AXIS_FULL) ? rsdz_pkg::AXIS_FULL : qx;
    end
    if (f.neg_y) begin
      dy_next = 16'(-qy);
    end else begin
      dy_next = (qy > rsdz_pkg::AXIS_FULL) ? rsdz_pkg::AXIS_FULL : qy;
    end
    nm_next = f.dz_full ? 16'd0 : qn;
    if (f.dz_hit) begin
      dx_next = '0;
      dy_next = '0;
      nm_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f.valid;
    end
    if (en) begin
      dir_x          <= dx_next;
      dir_y          <= dy_next;
      norm_magnitude <= nm_next;
      in_dead_zone   <= f.dz_hit;
    end
  end

endmodule

[design/rsdz_checker.sv]
// ---------------------------------------------------------------------------
// rsdz_checker
// Port-level checks for the radial dead zone block.
// ---------------------------------------------------------------------------
module rsdz_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [15:0]      dir_x,
  input logic signed [15:0]      dir_y,
  input logic [15:0]             norm_magnitude,
  input logic                    in_dead_zone
);

  // Inside the dead zone every value is zero.
  a_zero_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_dead_zone |-> dir_x == 16'sd0 && dir_y == 16'sd0
                                 && norm_magnitude == 16'd0)
    else $error("nonzero result inside dead zone");

  // Magnitude never exceeds 1.0.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_magnitude <= 16'd32768)
    else $error("magnitude above full scale");

  // Input holds exactly while an output request waits.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output back-pressure");

  // Held result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dir_x) && $stable(dir_y)
                               && $stable(norm_magnitude) && $stable(in_dead_zone))
    else $error("stalled result changed");

endmodule

bind radial_stick_dead_zone rsdz_checker u_rsdz_checker (.*);
